### rtl/named_timer_table_scheduler_macros.svh
// Assertion macros shared by the timer scheduler RTL.
`ifndef NAMED_TIMER_TABLE_SCHEDULER_MACROS_SVH
`define NAMED_TIMER_TABLE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NTTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ntts: assertion failed");

// Next-cycle implication, checked out of reset.
`define NTTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ntts: assertion failed");

`endif

### rtl/ntts_pkg.sv
// Types and constants of the timer table scheduler.
package ntts_pkg;

  // Opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ADD_IV  = 3'd1;
  localparam logic [2:0] OP_ADD_TO  = 3'd2;
  localparam logic [2:0] OP_ADD_DF  = 3'd3;
  localparam logic [2:0] OP_CAN_IV  = 3'd4;
  localparam logic [2:0] OP_CAN_TO  = 3'd5;
  localparam logic [2:0] OP_CAN_DF  = 3'd6;
  localparam logic [2:0] OP_UNUSED  = 3'd7;

  // Result status codes
  localparam logic [2:0] ST_FIRED  = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_ACCEPT = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_HIT    = 3'd4;
  localparam logic [2:0] ST_MISS   = 3'd5;

  // Entry kinds
  localparam logic [1:0] KIND_INTERVAL = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd1;
  localparam logic [1:0] KIND_DEFER    = 2'd2;

  localparam logic [31:0] NEVER_PERIOD = 32'hFFFF_FFFF;

  // One table entry as held in the memory
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key;
    logic        named;
    logic [31:0] period;
    logic [31:0] last_run;
  } entry_t;

endpackage

### rtl/ntts_div.sv
// Serial 32-bit restoring divider, one quotient bit per cycle.
module ntts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [32:0] shifted;
  logic        fits;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem_q, quo_q[31]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], fits};
      rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/named_timer_table_scheduler.sv
// Timer table scheduler: entry memory, scan sequencer and result register.
//
//  channel  | dir | tdata (low bit up)                              | side bits
//  s_axis   | in  | timer_key, has_name, period, now_ms, random_word| tuser: opcode
//  m_axis   | out | fired_key, fired_named, fired_kind              | tuser: status, tlast
//
// An add or cancel is accepted, then scans and evaluates each entry searched and finishes;
// an add of an interval with nonzero period also runs the serial divider.
// A tick is accepted, scans and evaluates each entry, writes back each surviving entry,
// runs the divider, then multiply and add, for each due interval of nonzero period and
// finishes with a done beat.
// Reset clears the live bits and the entry count at once; no clearing pass.
// A stalled result register holds the sequencer until the beat is taken.
module named_timer_table_scheduler #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // key[7:0], has_name[8], period[40:9], now_ms[72:41], random_word[104:73]
  input  logic [111:0] s_axis_tdata_i,
  // opcode[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // fired_key[7:0], fired_named[8], fired_kind[10:9]
  output logic [15:0]  m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  `include "named_timer_table_scheduler_macros.svh"

  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int IW = $clog2(TABLE_SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_KEEP = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_POST = 4'd7;
  localparam logic [3:0] S_ADIV = 4'd8;
  localparam logic [3:0] S_AWR  = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  key_q, key_d;
  logic        named_q, named_d;
  logic [31:0] period_q, period_d;
  logic [31:0] now_q, now_d;
  logic [31:0] rnd_q, rnd_d;
  logic [31:0] off_q, off_d;
  logic [31:0] prod_q, prod_d;
  logic        hit_q, hit_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] count_q, count_d;
  logic [TABLE_SLOTS-1:0] live_q, live_d;
  ntts_pkg::entry_t ent_q, ent_d;

  // entry memory
  ntts_pkg::entry_t mem_q [TABLE_SLOTS];
  ntts_pkg::entry_t mem_rd_q;
  ntts_pkg::entry_t mem_wd;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_ra;

  // result register
  logic       out_valid_q;
  logic [2:0] out_status_q, emit_status;
  logic [7:0] out_key_q, emit_key;
  logic       out_named_q, emit_named;
  logic [1:0] out_kind_q, emit_kind;
  logic       out_last_q, emit_last;
  logic       emit;
  logic       can_emit;

  // divider
  logic        div_start;
  logic [31:0] div_a, div_b;
  logic        div_busy, div_done;
  logic [31:0] div_quot, div_rem;

  logic        is_tick;
  logic        is_add;
  logic        cur_live;
  logic [31:0] elapsed;
  logic        due;

  ntts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign can_emit = !out_valid_q || m_axis_tready_i;
  assign is_tick  = op_q == ntts_pkg::OP_TICK;
  assign is_add   = (op_q == ntts_pkg::OP_ADD_IV) || (op_q == ntts_pkg::OP_ADD_TO) ||
                    (op_q == ntts_pkg::OP_ADD_DF);
  assign mem_ra   = idx_q[IW-1:0];
  assign cur_live = live_q[idx_q[IW-1:0]];
  assign elapsed  = now_q - mem_rd_q.last_run;
  assign due      = cur_live && ((mem_rd_q.kind == ntts_pkg::KIND_DEFER) ||
                    ((mem_rd_q.period != ntts_pkg::NEVER_PERIOD) &&
                     (elapsed > mem_rd_q.period)));
  assign prod_d   = 32'(div_quot * ent_q.period);

  // sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    kind_d   = kind_q;
    key_d    = key_q;
    named_d  = named_q;
    period_d = period_q;
    now_d    = now_q;
    rnd_d    = rnd_q;
    off_d    = off_q;
    hit_d    = hit_q;
    idx_d    = idx_q;
    wr_d     = wr_q;
    count_d  = count_q;
    live_d   = live_q;
    ent_d    = ent_q;
    mem_we   = 1'b0;
    mem_wa   = wr_q[IW-1:0];
    mem_wd   = ent_q;
    div_start = 1'b0;
    div_a    = rnd_q;
    div_b    = period_q;
    emit        = 1'b0;
    emit_status = ntts_pkg::ST_DONE;
    emit_key    = key_q;
    emit_named  = named_q;
    emit_kind   = kind_q;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tuser_i;
          key_d    = s_axis_tdata_i[7:0];
          named_d  = s_axis_tdata_i[8];
          period_d = s_axis_tdata_i[40:9];
          now_d    = s_axis_tdata_i[72:41];
          rnd_d    = s_axis_tdata_i[104:73];
          off_d    = '0;
          hit_d    = 1'b0;
          idx_d    = '0;
          wr_d     = '0;
          unique case (s_axis_tuser_i) inside
            ntts_pkg::OP_ADD_IV, ntts_pkg::OP_CAN_IV: kind_d = ntts_pkg::KIND_INTERVAL;
            ntts_pkg::OP_ADD_TO, ntts_pkg::OP_CAN_TO: kind_d = ntts_pkg::KIND_TIMEOUT;
            default:                                  kind_d = ntts_pkg::KIND_DEFER;
          endcase
          if (s_axis_tuser_i != ntts_pkg::OP_UNUSED) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q == count_q) begin
          state_d = is_tick ? S_FIN : S_POST;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        ent_d = mem_rd_q;
        if (is_tick) begin
          if (due) begin
            if (can_emit) begin
              emit        = 1'b1;
              emit_status = ntts_pkg::ST_FIRED;
              emit_key    = mem_rd_q.key;
              emit_named  = mem_rd_q.named;
              emit_kind   = mem_rd_q.kind;
              emit_last   = 1'b0;
              if (mem_rd_q.kind != ntts_pkg::KIND_INTERVAL) begin
                live_d[idx_q[IW-1:0]] = 1'b0;
                idx_d   = idx_q + 1'b1;
                state_d = S_SCAN;
              end else if (mem_rd_q.period != '0) begin
                div_start = 1'b1;
                div_a     = elapsed;
                div_b     = mem_rd_q.period;
                state_d   = S_DIV;
              end else begin
                state_d = S_KEEP;
              end
            end
          end else if (cur_live) begin
            state_d = S_KEEP;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN;
          end
        end else begin
          // first live named entry of the same kind and key
          if (cur_live && mem_rd_q.named && named_q && (mem_rd_q.key == key_q) &&
              (mem_rd_q.kind == kind_q)) begin
            live_d[idx_q[IW-1:0]] = 1'b0;
            hit_d   = 1'b1;
            state_d = S_POST;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        ent_d.last_run = ent_q.last_run + prod_q;
        state_d = S_KEEP;
      end
      S_KEEP: begin
        // compaction: move the surviving entry down to the write slot
        mem_we = 1'b1;
        if (wr_q != idx_q) begin
          live_d[idx_q[IW-1:0]] = 1'b0;
        end
        live_d[wr_q[IW-1:0]] = 1'b1;
        wr_d    = wr_q + 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_SCAN;
      end
      S_FIN: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_status = ntts_pkg::ST_DONE;
          emit_key    = '0;
          emit_named  = 1'b0;
          emit_kind   = '0;
          count_d     = wr_q;
          state_d     = S_IDLE;
        end
      end
      S_POST: begin
        if (!is_add) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_status = hit_q ? ntts_pkg::ST_HIT : ntts_pkg::ST_MISS;
            emit_named  = hit_q | named_q;
            state_d     = S_IDLE;
          end
        end else if (count_q == CW'(TABLE_SLOTS)) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_status = ntts_pkg::ST_FULL;
            state_d     = S_IDLE;
          end
        end else if ((kind_q == ntts_pkg::KIND_INTERVAL) && (period_q != '0)) begin
          div_start = 1'b1;
          state_d   = S_ADIV;
        end else begin
          state_d = S_AWR;
        end
      end
      S_ADIV: begin
        if (div_done) begin
          off_d   = {1'b0, div_rem[31:1]};
          state_d = S_AWR;
        end
      end
      S_AWR: begin
        if (can_emit) begin
          emit           = 1'b1;
          emit_status    = ntts_pkg::ST_ACCEPT;
          mem_we         = 1'b1;
          mem_wa         = count_q[IW-1:0];
          mem_wd.kind    = kind_q;
          mem_wd.key     = key_q;
          mem_wd.named   = named_q;
          case (kind_q)
            ntts_pkg::KIND_INTERVAL: begin
              mem_wd.period   = period_q;
              mem_wd.last_run = now_q - period_q - off_q;
            end
            ntts_pkg::KIND_TIMEOUT: begin
              mem_wd.period   = period_q;
              mem_wd.last_run = now_q;
            end
            default: begin
              mem_wd.period   = '0;
              mem_wd.last_run = '0;
            end
          endcase
          live_d[count_q[IW-1:0]] = 1'b1;
          count_d = count_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      live_q  <= live_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    kind_q   <= kind_d;
    key_q    <= key_d;
    named_q  <= named_d;
    period_q <= period_d;
    now_q    <= now_d;
    rnd_q    <= rnd_d;
    off_q    <= off_d;
    hit_q    <= hit_d;
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    ent_q    <= ent_d;
    prod_q   <= prod_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_key_q    <= emit_key;
      out_named_q  <= emit_named;
      out_kind_q   <= emit_kind;
      out_last_q   <= emit_last;
    end
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_kind_q, out_named_q, out_key_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // checks
  `NTTS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(TABLE_SLOTS))
  `NTTS_ASSERT_IMP(a_live_below_count, clk_i, rst_ni, 1'b1, (live_q >> count_q) == '0)
  `NTTS_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, emit, can_emit)
  `NTTS_ASSERT_IMP(a_div_owner, clk_i, rst_ni, div_busy, (state_q == S_DIV) || (state_q == S_ADIV))
  `NTTS_ASSERT_IMP(a_wr_behind_rd, clk_i, rst_ni, state_q != S_IDLE, wr_q <= idx_q)

endmodule
